### rtl/fpcr_pkg.sv
package fpcr_pkg;

	localparam int MAX_PAYLOAD_DEF = 32;
	localparam int ROUTES_DEF      = 4;

	// payload length held with room for the largest allowed limit
	localparam int LEN_W    = 7;
	localparam int ROUTE_W  = 2;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W    = 16;

	localparam logic [CFG_IDX_W-1:0] REG_START_BYTE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROUTE_COUNT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROUTE0      = 3'd2;

	localparam logic [7:0] START_RESET = 8'hAA;

	typedef enum logic [2:0] {
		PH_START,
		PH_LEN,
		PH_DATA,
		PH_CMD,
		PH_CHECK
	} phase_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_READ,
		BK_LOAD
	} back_t;

	typedef struct packed {
		logic [ROUTE_W-1:0] route;
		logic [7:0]         command;
		logic [LEN_W-1:0]   length;
		logic               bank;
	} frame_desc_t;

endpackage

### rtl/fpcr_front.sv
module fpcr_front #(
	parameter int MAX_PAYLOAD = fpcr_pkg::MAX_PAYLOAD_DEF,
	parameter int ROUTES      = fpcr_pkg::ROUTES_DEF,
	parameter int AW          = 1,
	parameter int LW          = 1
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [fpcr_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [fpcr_pkg::CFG_W-1:0]       cfg_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [7:0]                       rx_byte,
	input  logic                             q_full,
	output logic                             q_push,
	output fpcr_pkg::frame_desc_t            q_desc,
	output logic                             mem_we,
	output logic [AW:0]                      mem_addr,
	output logic [7:0]                       mem_data
);

	fpcr_pkg::phase_t phase_q, phase_nx;

	logic [7:0]  start_q;
	logic [2:0]  rcount_q;
	logic [15:0] routes_q [ROUTES];

	logic [7:0]    sum_q;
	logic [LW-1:0] len_q;
	logic [LW-1:0] cnt_q;
	logic [7:0]    cmd_q;
	logic          bank_q;

	logic          acc;
	logic [2:0]    rcount_eff;
	logic          found;
	logic [fpcr_pkg::ROUTE_W-1:0] found_idx;
	logic [7:0]    found_need;
	logic          route_ok;
	logic [LW-1:0] cnt_inc;

	assign in_stall = q_full;
	assign acc      = in_valid && !in_stall;
	assign cnt_inc  = cnt_q + LW'(1);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q  <= fpcr_pkg::START_RESET;
			rcount_q <= '0;
			for (int i = 0; i < ROUTES; i++) begin
				routes_q[i] <= '0;
			end
		end else if (cfg_we) begin
			if (cfg_index == fpcr_pkg::REG_START_BYTE) begin
				start_q <= cfg_data[7:0];
			end
			if (cfg_index == fpcr_pkg::REG_ROUTE_COUNT) begin
				rcount_q <= cfg_data[2:0];
			end
			for (int i = 0; i < ROUTES; i++) begin
				if (cfg_index == fpcr_pkg::REG_ROUTE0 + fpcr_pkg::CFG_IDX_W'(i)) begin
					routes_q[i] <= cfg_data;
				end
			end
		end
	end

	// first route with a matching command decides
	always_comb begin
		rcount_eff = (rcount_q > 3'(ROUTES)) ? 3'(ROUTES) : rcount_q;
		found      = 1'b0;
		found_idx  = '0;
		found_need = '0;
		for (int i = 0; i < ROUTES; i++) begin
			if (!found && (3'(i) < rcount_eff) && (routes_q[i][7:0] == cmd_q)) begin
				found      = 1'b1;
				found_idx  = fpcr_pkg::ROUTE_W'(i);
				found_need = routes_q[i][15:8];
			end
		end
		route_ok = found && ((found_need == 8'd0) || (found_need == 8'(len_q)));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= fpcr_pkg::PH_START;
		end else begin
			phase_q <= phase_nx;
		end
	end

	always_comb begin
		phase_nx = phase_q;
		q_push   = 1'b0;
		mem_we   = 1'b0;
		if (acc) begin
			unique case (phase_q)
				fpcr_pkg::PH_START: begin
					if (rx_byte == start_q) begin
						phase_nx = fpcr_pkg::PH_LEN;
					end
				end
				fpcr_pkg::PH_LEN: begin
					if (rx_byte <= 8'(MAX_PAYLOAD)) begin
						phase_nx = (rx_byte != 8'd0) ? fpcr_pkg::PH_DATA : fpcr_pkg::PH_CMD;
					end else begin
						phase_nx = fpcr_pkg::PH_START;
					end
				end
				fpcr_pkg::PH_DATA: begin
					mem_we = 1'b1;
					if (cnt_inc >= len_q) begin
						phase_nx = fpcr_pkg::PH_CMD;
					end
				end
				fpcr_pkg::PH_CMD: begin
					phase_nx = fpcr_pkg::PH_CHECK;
				end
				fpcr_pkg::PH_CHECK: begin
					q_push   = (rx_byte == sum_q) && route_ok;
					phase_nx = fpcr_pkg::PH_START;
				end
				default: begin
					phase_nx = fpcr_pkg::PH_START;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q  <= '0;
			len_q  <= '0;
			cnt_q  <= '0;
			cmd_q  <= '0;
			bank_q <= 1'b0;
		end else if (acc) begin
			unique case (phase_q)
				fpcr_pkg::PH_START: begin
					if (rx_byte == start_q) begin
						sum_q <= rx_byte;
					end
				end
				fpcr_pkg::PH_LEN: begin
					if (rx_byte <= 8'(MAX_PAYLOAD)) begin
						len_q <= LW'(rx_byte);
						sum_q <= sum_q + rx_byte;
						cnt_q <= '0;
					end
				end
				fpcr_pkg::PH_DATA: begin
					cnt_q <= cnt_inc;
					sum_q <= sum_q + rx_byte;
				end
				fpcr_pkg::PH_CMD: begin
					cmd_q <= rx_byte;
					sum_q <= sum_q + rx_byte;
				end
				fpcr_pkg::PH_CHECK: begin
					// each queued frame owns one payload bank
					if (q_push) begin
						bank_q <= !bank_q;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign mem_addr = {bank_q, cnt_q[AW-1:0]};
	assign mem_data = rx_byte;

	assign q_desc.route   = found_idx;
	assign q_desc.command = cmd_q;
	assign q_desc.length  = fpcr_pkg::LEN_W'(len_q);
	assign q_desc.bank    = bank_q;

endmodule

### rtl/fpcr_queue.sv
module fpcr_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  fpcr_pkg::frame_desc_t push_desc,
	input  logic                  pop,
	output logic                  full,
	output logic                  head_valid,
	output fpcr_pkg::frame_desc_t head_desc
);

	fpcr_pkg::frame_desc_t slot_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] count_q;

	assign full       = (count_q == 2'd2);
	assign head_valid = (count_q != 2'd0);
	assign head_desc  = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

endmodule

### rtl/fpcr_back.sv
module fpcr_back #(
	parameter int AW = 1,
	parameter int LW = 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  mem_we,
	input  logic [AW:0]           mem_addr,
	input  logic [7:0]            mem_data,
	input  logic                  head_valid,
	input  fpcr_pkg::frame_desc_t head_desc,
	output logic                  pop,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [1:0]            route_index,
	output logic [7:0]            frame_command,
	output logic [5:0]            frame_length,
	output logic                  has_byte,
	output logic [7:0]            payload_byte,
	output logic [4:0]            byte_position,
	output logic                  last
);

	// two banks so the next frame can land while this one drains
	logic [7:0] mem [2 << AW];
	logic [7:0] rd_q;

	fpcr_pkg::back_t st_q, st_nx;
	logic [LW-1:0] k_q;
	logic [LW-1:0] len;
	logic          empty_frame;
	logic          is_last;
	logic          out_free;
	logic          load;

	logic                          out_valid_q;
	logic [fpcr_pkg::ROUTE_W-1:0]  route_q;
	logic [7:0]                    cmd_q;
	logic [5:0]                    len_out_q;
	logic                          has_q;
	logic [7:0]                    byte_q;
	logic [4:0]                    pos_q;
	logic                          last_q;

	assign len         = LW'(head_desc.length);
	assign empty_frame = (len == '0);
	assign is_last     = empty_frame || (k_q + LW'(1) == len);
	assign out_free    = !out_valid_q || !out_stall;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_data;
		end
		rd_q <= mem[{head_desc.bank, k_q[AW-1:0]}];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= fpcr_pkg::BK_IDLE;
		end else begin
			st_q <= st_nx;
		end
	end

	always_comb begin
		st_nx = st_q;
		load  = 1'b0;
		pop   = 1'b0;
		unique case (st_q)
			fpcr_pkg::BK_IDLE: begin
				if (head_valid) begin
					st_nx = empty_frame ? fpcr_pkg::BK_LOAD : fpcr_pkg::BK_READ;
				end
			end
			fpcr_pkg::BK_READ: begin
				st_nx = fpcr_pkg::BK_LOAD;
			end
			fpcr_pkg::BK_LOAD: begin
				if (out_free) begin
					load = 1'b1;
					// bank stays owned until its last byte is read
					pop   = is_last;
					st_nx = is_last ? fpcr_pkg::BK_IDLE : fpcr_pkg::BK_READ;
				end
			end
			default: begin
				st_nx = fpcr_pkg::BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				k_q <= is_last ? '0 : k_q + LW'(1);
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			route_q   <= head_desc.route;
			cmd_q     <= head_desc.command;
			len_out_q <= 6'(head_desc.length);
			has_q     <= !empty_frame;
			byte_q    <= empty_frame ? 8'd0 : rd_q;
			pos_q     <= 5'(k_q);
			last_q    <= is_last;
		end
	end

	assign out_valid     = out_valid_q;
	assign route_index   = route_q;
	assign frame_command = cmd_q;
	assign frame_length  = len_out_q;
	assign has_byte      = has_q;
	assign payload_byte  = byte_q;
	assign byte_position = pos_q;
	assign last          = last_q;

endmodule

### rtl/frame_parser_with_command_routing_top.sv
// throughput: input takes one word per cycle while not stalled; each result word waits for
// the registered payload memory read ahead of its output load
// input stalls while two good frames are still waiting to be drained
// reset: async active low; parser hunts for start, queue empty, registers at defaults
module frame_parser_with_command_routing_top #(
	parameter int MAX_PAYLOAD = fpcr_pkg::MAX_PAYLOAD_DEF,
	parameter int ROUTES      = fpcr_pkg::ROUTES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [fpcr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [fpcr_pkg::CFG_W-1:0]     cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [7:0]                     rx_byte,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [1:0]                     route_index,
	output logic [7:0]                     frame_command,
	output logic [5:0]                     frame_length,
	output logic                           has_byte,
	output logic [7:0]                     payload_byte,
	output logic [4:0]                     byte_position,
	output logic                           last
);

	localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
	localparam int LW = $clog2(MAX_PAYLOAD + 1);

	logic                  q_full;
	logic                  q_push;
	logic                  q_pop;
	logic                  head_valid;
	fpcr_pkg::frame_desc_t push_desc;
	fpcr_pkg::frame_desc_t head_desc;
	logic                  mem_we;
	logic [AW:0]           mem_addr;
	logic [7:0]            mem_data;

	fpcr_front #(
		.MAX_PAYLOAD (MAX_PAYLOAD),
		.ROUTES      (ROUTES),
		.AW          (AW),
		.LW          (LW)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.rx_byte   (rx_byte),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_desc    (push_desc),
		.mem_we    (mem_we),
		.mem_addr  (mem_addr),
		.mem_data  (mem_data)
	);

	fpcr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_desc  (push_desc),
		.pop        (q_pop),
		.full       (q_full),
		.head_valid (head_valid),
		.head_desc  (head_desc)
	);

	fpcr_back #(
		.AW (AW),
		.LW (LW)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.mem_we        (mem_we),
		.mem_addr      (mem_addr),
		.mem_data      (mem_data),
		.head_valid    (head_valid),
		.head_desc     (head_desc),
		.pop           (q_pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.route_index   (route_index),
		.frame_command (frame_command),
		.frame_length  (frame_length),
		.has_byte      (has_byte),
		.payload_byte  (payload_byte),
		.byte_position (byte_position),
		.last          (last)
	);

endmodule

### tb/sv/frame_parser_with_command_routing_top_tb.sv
module frame_parser_with_command_routing_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_LEN    = fpcr_pkg::MAX_PAYLOAD_DEF;
	localparam int QUIET_MAX  = 2000;
	localparam int SETTLE_CYC = 8;

	typedef struct packed {
		logic [1:0] route;
		logic [7:0] command;
		logic [5:0] length;
		logic       has_byte;
		logic [7:0] data;
		logic [4:0] position;
		logic       last;
	} route_word_t;

	logic                           clk;
	logic                           arst_n    = 1'b0;
	logic                           cfg_we    = 1'b0;
	logic [fpcr_pkg::CFG_IDX_W-1:0] cfg_index = fpcr_pkg::REG_START_BYTE;
	logic [fpcr_pkg::CFG_W-1:0]     cfg_data  = '0;
	logic                           in_valid  = 1'b0;
	logic                           in_stall;
	logic [7:0]                     rx_byte   = 8'h00;
	logic                           out_valid;
	logic                           out_stall = 1'b0;
	logic [1:0]                     route_index;
	logic [7:0]                     frame_command;
	logic [5:0]                     frame_length;
	logic                           has_byte;
	logic [7:0]                     payload_byte;
	logic [4:0]                     byte_position;
	logic                           last;

	frame_parser_with_command_routing_top DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.rx_byte       (rx_byte),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.route_index   (route_index),
		.frame_command (frame_command),
		.frame_length  (frame_length),
		.has_byte      (has_byte),
		.payload_byte  (payload_byte),
		.byte_position (byte_position),
		.last          (last)
	);

	// register copies
	logic [7:0]  cfg_start = fpcr_pkg::START_RESET;
	logic [2:0]  cfg_routes = '0;
	logic [15:0] cfg_entry [4] = '{default: '0};

	// parser state
	fpcr_pkg::phase_t parse_phase = fpcr_pkg::PH_START;
	logic [7:0] frame_sum = '0;
	int         data_count = 0;
	logic [5:0] frame_len = '0;
	logic [7:0] frame_cmd = '0;
	logic [7:0] frame_bytes [MAX_LEN];

	route_word_t routed_q[$];
	logic [7:0]  rx_q[$];
	int          words_made = 0;
	bit          in_busy = 0;
	int          in_gap = 0;
	int          out_gap = 0;
	bit          idling = 1;
	int          quiet = 0;
	int          failures = 0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// first matching route decides; later routes with the same command are ignored
	function automatic void route_frame();
		int         n_routes;
		logic [7:0] need;
		route_word_t w;
		n_routes = (cfg_routes > fpcr_pkg::ROUTES_DEF) ? fpcr_pkg::ROUTES_DEF : int'(cfg_routes);
		for (int i = 0; i < n_routes; i++) begin
			if (cfg_entry[i][7:0] == frame_cmd) begin
				need = cfg_entry[i][15:8];
				if (need != 0 && need != frame_len)
					return;
				w.route = 2'(i);
				w.command = frame_cmd;
				if (frame_len == 0) begin
					w.length = '0;
					w.has_byte = 1'b0;
					w.data = '0;
					w.position = '0;
					w.last = 1'b1;
					routed_q.push_back(w);
				end else begin
					for (int k = 0; k < frame_len; k++) begin
						w.length = frame_len;
						w.has_byte = 1'b1;
						w.data = frame_bytes[k];
						w.position = 5'(k);
						w.last = (k == frame_len - 1);
						routed_q.push_back(w);
					end
				end
				return;
			end
		end
	endfunction

	function automatic void parse_rx_byte(input logic [7:0] b);
		case (parse_phase)
			fpcr_pkg::PH_START: begin
				if (b == cfg_start) begin
					frame_sum = b;
					parse_phase = fpcr_pkg::PH_LEN;
				end
			end
			fpcr_pkg::PH_LEN: begin
				// an oversized length is dropped, not taken as a new start
				if (b <= MAX_LEN) begin
					frame_len = 6'(b);
					frame_sum = frame_sum + b;
					data_count = 0;
					parse_phase = (b != 0) ? fpcr_pkg::PH_DATA : fpcr_pkg::PH_CMD;
				end else
					parse_phase = fpcr_pkg::PH_START;
			end
			fpcr_pkg::PH_DATA: begin
				if (data_count < MAX_LEN)
					frame_bytes[data_count] = b;
				data_count++;
				frame_sum = frame_sum + b;
				if (data_count >= frame_len)
					parse_phase = fpcr_pkg::PH_CMD;
			end
			fpcr_pkg::PH_CMD: begin
				frame_cmd = b;
				frame_sum = frame_sum + b;
				parse_phase = fpcr_pkg::PH_CHECK;
			end
			fpcr_pkg::PH_CHECK: begin
				if (b == frame_sum)
					route_frame();
				parse_phase = fpcr_pkg::PH_START;
			end
			default: parse_phase = fpcr_pkg::PH_START;
		endcase
	endfunction

	function automatic void push_word(input logic [7:0] b);
		rx_q.push_back(b);
		words_made++;
	endfunction

	// fill < 0 gives random payload words
	task automatic add_frame(input logic [7:0] len_byte, input logic [7:0] cmd,
			input bit bad_sum, input int fill = -1);
		logic [7:0] sum;
		logic [7:0] d;
		sum = cfg_start + len_byte;
		push_word(cfg_start);
		push_word(len_byte);
		if (len_byte > MAX_LEN)
			return;
		for (int k = 0; k < len_byte; k++) begin
			d = (fill < 0) ? 8'($urandom) : 8'(fill);
			push_word(d);
			sum = sum + d;
		end
		push_word(cmd);
		sum = sum + cmd;
		push_word(bad_sum ? (sum ^ 8'($urandom_range(1, 255))) : sum);
	endtask

	task automatic write_reg(input logic [fpcr_pkg::CFG_IDX_W-1:0] idx,
			input logic [fpcr_pkg::CFG_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == fpcr_pkg::REG_START_BYTE)
			cfg_start = value[7:0];
		else if (idx == fpcr_pkg::REG_ROUTE_COUNT)
			cfg_routes = value[2:0];
		else
			cfg_entry[idx - fpcr_pkg::REG_ROUTE0] = value;
	endtask

	task automatic wait_sent();
		while (rx_q.size() != 0 || in_busy)
			@(posedge clk);
	endtask

	// bring the parser back to hunting and let all results drain
	task automatic settle();
		wait_sent();
		while (parse_phase != fpcr_pkg::PH_START) begin
			push_word(8'hFF);
			wait_sent();
		end
		while (routed_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic random_traffic(input int budget);
		int         target;
		int         pick;
		int         r;
		logic [7:0] cmd;
		logic [7:0] need;
		logic [7:0] len;
		target = words_made + budget;
		while (words_made < target) begin
			pick = $urandom_range(0, 99);
			r = $urandom_range(0, 3);
			cmd = ($urandom_range(0, 9) != 0) ? cfg_entry[r][7:0] : 8'($urandom);
			need = cfg_entry[r][15:8];
			if (need != 0 && need <= MAX_LEN && $urandom_range(0, 2) != 0)
				len = need;
			else if ($urandom_range(0, 19) == 0)
				len = 8'(MAX_LEN);
			else
				len = 8'($urandom_range(0, 6));
			if (pick < 75)
				add_frame(len, cmd, 1'b0);
			else if (pick < 85)
				add_frame(len, cmd, 1'b1);
			else if (pick < 92)
				add_frame(8'($urandom_range(MAX_LEN + 1, 255)), cmd, 1'b0);
			else
				push_word(8'($urandom));
		end
	endtask

	task automatic random_config(input int p, input int n_phases);
		logic [15:0] entry;
		int          sel;
		if (p == 0)
			write_reg(fpcr_pkg::REG_START_BYTE, 16'h0000);
		else if (p == 1)
			write_reg(fpcr_pkg::REG_START_BYTE, 16'h00FF);
		else
			write_reg(fpcr_pkg::REG_START_BYTE, 16'($urandom_range(0, 255)));
		// a count past the number of routes is clamped by the block
		if (p == 2)
			write_reg(fpcr_pkg::REG_ROUTE_COUNT, 16'd7);
		else
			write_reg(fpcr_pkg::REG_ROUTE_COUNT, 16'($urandom_range(1, fpcr_pkg::ROUTES_DEF)));
		for (int i = 0; i < fpcr_pkg::ROUTES_DEF; i++) begin
			sel = $urandom_range(0, 9);
			entry[7:0] = 8'($urandom);
			if (sel < 5)
				entry[15:8] = 8'h00;
			else if (sel < 9)
				entry[15:8] = 8'($urandom_range(1, 8));
			else
				entry[15:8] = 8'($urandom);
			if (p == n_phases - 1 && i == 3)
				entry = 16'hFFFF;
			write_reg(fpcr_pkg::REG_ROUTE0 + fpcr_pkg::CFG_IDX_W'(i), entry);
		end
	endtask

	initial begin
		int n_phases;
		n_phases = 6;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset values: no routes, so a good frame is dropped
		add_frame(8'd0, 8'h00, 1'b0);
		push_word(8'h5A);
		settle();

		write_reg(fpcr_pkg::REG_START_BYTE, 16'h00AA);
		write_reg(fpcr_pkg::REG_ROUTE_COUNT, 16'd4);
		write_reg(fpcr_pkg::REG_ROUTE0, 16'h0010);
		write_reg(fpcr_pkg::REG_ROUTE0 + 3'd1, 16'h0420);
		write_reg(fpcr_pkg::REG_ROUTE0 + 3'd2, 16'h0310);
		write_reg(fpcr_pkg::REG_ROUTE0 + 3'd3, 16'hFFFF);
		add_frame(8'd0, 8'h10, 1'b0);
		add_frame(8'd1, 8'h10, 1'b0, 255);
		add_frame(8'd2, 8'h10, 1'b0, 0);
		add_frame(cfg_start, 8'h10, 1'b0);
		add_frame(8'd0, 8'h10, 1'b1);
		add_frame(8'd0, 8'h20, 1'b0);
		settle();

		for (int p = 0; p < n_phases; p++) begin
			idling = (p % 2 == 0) && (p != n_phases - 1);
			random_config(p, n_phases);
			random_traffic(26);
			settle();
		end

		while (routed_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (failures == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// byte driver
	always @(negedge clk) begin
		if (!in_busy) begin
			if (in_gap == 0 && idling && $urandom_range(0, 9) == 0)
				in_gap = $urandom_range(1, 13);
			if (in_gap > 0) begin
				in_gap--;
				in_valid <= 1'b0;
			end else if (rx_q.size() != 0) begin
				in_valid <= 1'b1;
				rx_byte <= rx_q[0];
				in_busy = 1;
			end else
				in_valid <= 1'b0;
		end
	end

	// result stall pattern
	always @(negedge clk) begin
		if (out_gap == 0 && idling && $urandom_range(0, 7) == 0)
			out_gap = $urandom_range(1, 13);
		if (out_gap > 0) begin
			out_gap--;
			out_stall <= 1'b1;
		end else
			out_stall <= 1'b0;
	end

	// monitor: check results, feed accepted words to the parser copy
	always @(posedge clk) begin
		route_word_t want;
		bit          moved;
		moved = 0;
		if (arst_n && out_valid && !out_stall) begin
			moved = 1;
			if (routed_q.size() == 0) begin
				$error("unexpected result word: route_index %0d payload_byte %0d",
					route_index, payload_byte);
				failures++;
			end else begin
				want = routed_q.pop_front();
				if (route_index !== want.route) begin
					$error("route_index: expected %0d, got %0d", want.route, route_index);
					failures++;
				end
				if (frame_command !== want.command) begin
					$error("frame_command: expected %0d, got %0d", want.command,
						frame_command);
					failures++;
				end
				if (frame_length !== want.length) begin
					$error("frame_length: expected %0d, got %0d", want.length, frame_length);
					failures++;
				end
				if (has_byte !== want.has_byte) begin
					$error("has_byte: expected %0d, got %0d", want.has_byte, has_byte);
					failures++;
				end
				if (payload_byte !== want.data) begin
					$error("payload_byte: expected %0d, got %0d", want.data, payload_byte);
					failures++;
				end
				if (byte_position !== want.position) begin
					$error("byte_position: expected %0d, got %0d", want.position,
						byte_position);
					failures++;
				end
				if (last !== want.last) begin
					$error("last: expected %0d, got %0d", want.last, last);
					failures++;
				end
			end
		end
		if (arst_n && in_valid && !in_stall) begin
			moved = 1;
			parse_rx_byte(rx_byte);
			void'(rx_q.pop_front());
			in_busy = 0;
		end
		quiet = (moved || !arst_n) ? 0 : quiet + 1;
		if (quiet >= QUIET_MAX) begin
			$display("Test completed with failures");
			$finish;
		end
	end

endmodule
